@@ rtl/core/kvrp_pkg.sv @@
// kvrp_pkg: shared types, byte codes and result codes of the reply parser.
// Depends on nothing; imported by every module under rtl/core.
package kvrp_pkg;

	localparam int NUMBER_WIDTH_DEF = 32;
	localparam int CFG_W            = 31;
	localparam logic [CFG_W-1:0] MAX_BULK_RESET = 31'd536870912;
	localparam logic [31:0] LEN_CAP = 32'h8000_0000;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [1:0] EV_CONTENT = 2'd0;
	localparam logic [1:0] EV_DONE    = 2'd1;
	localparam logic [1:0] EV_ERROR   = 2'd2;

	localparam logic [2:0] KIND_SIMPLE = 3'd0;
	localparam logic [2:0] KIND_ERRSTR = 3'd1;
	localparam logic [2:0] KIND_BULK   = 3'd2;
	localparam logic [2:0] KIND_INT    = 3'd3;
	localparam logic [2:0] KIND_ARRAY  = 3'd4;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_BAD_TYPE = 3'd1;
	localparam logic [2:0] ERR_ARRAY    = 3'd2;
	localparam logic [2:0] ERR_NO_LF    = 3'd3;
	localparam logic [2:0] ERR_BAD_LEN  = 3'd4;
	localparam logic [2:0] ERR_BAD_DIG  = 3'd5;
	localparam logic [2:0] ERR_TOO_LONG = 3'd6;
	localparam logic [2:0] ERR_OVERFLOW = 3'd7;

	typedef enum logic [9:0] {
		PH_IDLE    = 10'b00_0000_0001,
		PH_LINE    = 10'b00_0000_0010,
		PH_LINE_LF = 10'b00_0000_0100,
		PH_INT     = 10'b00_0000_1000,
		PH_INT_LF  = 10'b00_0001_0000,
		PH_LEN     = 10'b00_0010_0000,
		PH_LEN_LF  = 10'b00_0100_0000,
		PH_DATA    = 10'b00_1000_0000,
		PH_DATA_CR = 10'b01_0000_0000,
		PH_DATA_LF = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  event_kind;
		logic [2:0]  reply_kind;
		logic [7:0]  content_byte;
		logic [31:0] integer_value;
		logic        is_null;
		logic [2:0]  err_code;
	} result_t;

endpackage

@@ rtl/core/kvrp_num_acc.sv @@
// kvrp_num_acc: one decimal digit step of the number accumulator, x10 plus digit,
// with saturation at the integer limit or the bulk length cap. Uses kvrp_pkg.
module kvrp_num_acc
	import kvrp_pkg::*;
#(
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
	localparam int ACC_W = (NUMBER_WIDTH > 32) ? NUMBER_WIDTH : 32
) (
	input  logic [ACC_W-1:0] acc,
	input  logic [3:0]       digit,
	input  logic             int_mode,
	input  logic             negative,
	input  logic             ovf,
	output logic [ACC_W-1:0] acc_next,
	output logic             ovf_next
);

	localparam int PW = ACC_W + 4;
	localparam logic [PW-1:0] INT_TOP = PW'(1) << (NUMBER_WIDTH - 1);

	logic [PW-1:0] wide;
	logic [PW-1:0] prod;
	logic [PW-1:0] cap;
	logic          sat;

	assign wide = {4'b0000, acc};
	assign prod = (wide << 3) + (wide << 1) + {{(PW-4){1'b0}}, digit};

	always_comb begin
		if (int_mode) begin
			cap = negative ? INT_TOP : INT_TOP - PW'(1);
		end else begin
			cap = {{(PW-32){1'b0}}, LEN_CAP};
		end
	end

	// once an integer has saturated it stays at its limit
	assign sat      = (prod > cap) || (int_mode && ovf);
	assign acc_next = sat ? cap[ACC_W-1:0] : prod[ACC_W-1:0];
	assign ovf_next = int_mode ? (ovf | sat) : ovf;

endmodule

@@ rtl/core/kvrp_parser.sv @@
// kvrp_parser: reply state machine and per-byte result decode.
// Depends on kvrp_pkg and kvrp_num_acc.
module kvrp_parser
	import kvrp_pkg::*;
#(
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	input  logic [CFG_W-1:0] max_bulk,
	output result_t          res
);

	localparam int ACC_W = (NUMBER_WIDTH > 32) ? NUMBER_WIDTH : 32;

	phase_t           phase_q, phase_d;
	logic [2:0]       kind_q, kind_d;
	logic             neg_q, neg_d;
	logic             seen_q, seen_d;
	logic             ovf_q, ovf_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [30:0]      rem_q, rem_d;

	logic             is_digit;
	logic [ACC_W-1:0] acc_step;
	logic             ovf_step;
	logic [ACC_W-1:0] acc_neg;
	logic [30:0]      rem_dec;

	assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign acc_neg  = '0 - acc_q;
	assign rem_dec  = rem_q - 31'd1;

	kvrp_num_acc #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_acc (
		.acc      (acc_q),
		.digit    (byte_in[3:0]),
		.int_mode (phase_q == PH_INT),
		.negative (neg_q),
		.ovf      (ovf_q),
		.acc_next (acc_step),
		.ovf_next (ovf_step)
	);

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		neg_d   = neg_q;
		seen_d  = seen_q;
		ovf_d   = ovf_q;
		acc_d   = acc_q;
		rem_d   = rem_q;
		res     = '0;

		unique case (phase_q)
			PH_IDLE: begin
				neg_d  = 1'b0;
				seen_d = 1'b0;
				ovf_d  = 1'b0;
				acc_d  = '0;
				rem_d  = '0;
				unique case (byte_in)
					CH_PLUS: begin
						kind_d  = KIND_SIMPLE;
						phase_d = PH_LINE;
					end
					CH_MINUS: begin
						kind_d  = KIND_ERRSTR;
						phase_d = PH_LINE;
					end
					CH_DOLLAR: begin
						kind_d  = KIND_BULK;
						phase_d = PH_LEN;
					end
					CH_COLON: begin
						kind_d  = KIND_INT;
						phase_d = PH_INT;
					end
					CH_STAR: begin
						// arrays are not parsed; state other than kind is left alone
						neg_d  = neg_q;
						seen_d = seen_q;
						ovf_d  = ovf_q;
						acc_d  = acc_q;
						rem_d  = rem_q;
						kind_d = KIND_ARRAY;
						res    = '{1'b1, EV_ERROR, KIND_ARRAY, 8'd0, 32'd0, 1'b0, ERR_ARRAY};
					end
					default: begin
						neg_d  = neg_q;
						seen_d = seen_q;
						ovf_d  = ovf_q;
						acc_d  = acc_q;
						rem_d  = rem_q;
						kind_d = KIND_SIMPLE;
						res    = '{1'b1, EV_ERROR, KIND_SIMPLE, 8'd0, 32'd0, 1'b0,
							ERR_BAD_TYPE};
					end
				endcase
			end
			PH_LINE: begin
				if (byte_in == CH_CR) begin
					phase_d = PH_LINE_LF;
				end else begin
					res = '{1'b1, EV_CONTENT, kind_q, byte_in, 32'd0, 1'b0, ERR_NONE};
				end
			end
			PH_LINE_LF: begin
				phase_d = PH_IDLE;
				if (byte_in != CH_LF) begin
					res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_NO_LF};
				end else begin
					res = '{1'b1, EV_DONE, kind_q, 8'd0, 32'd0, 1'b0, ERR_NONE};
				end
			end
			PH_INT: begin
				priority if (byte_in == CH_CR) begin
					if (!seen_q) begin
						phase_d = PH_IDLE;
						res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_BAD_DIG};
					end else begin
						phase_d = PH_INT_LF;
					end
				end else if (byte_in == CH_MINUS && !seen_q && !neg_q) begin
					neg_d = 1'b1;
				end else if (!is_digit) begin
					phase_d = PH_IDLE;
					res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_BAD_DIG};
				end else begin
					seen_d = 1'b1;
					acc_d  = acc_step;
					ovf_d  = ovf_step;
				end
			end
			PH_INT_LF: begin
				phase_d = PH_IDLE;
				if (byte_in != CH_LF) begin
					res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_NO_LF};
				end else begin
					res = '{1'b1, EV_DONE, kind_q, 8'd0,
						neg_q ? acc_neg[31:0] : acc_q[31:0], 1'b0,
						ovf_q ? ERR_OVERFLOW : ERR_NONE};
				end
			end
			PH_LEN: begin
				priority if (byte_in == CH_CR) begin
					priority if (!seen_q) begin
						phase_d = PH_IDLE;
						res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_BAD_LEN};
					end else if (neg_q && acc_q != ACC_W'(1)) begin
						// only -1 is a legal negative length
						phase_d = PH_IDLE;
						res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_BAD_LEN};
					end else if (!neg_q && acc_q > ACC_W'(max_bulk)) begin
						phase_d = PH_IDLE;
						res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_TOO_LONG};
					end else begin
						phase_d = PH_LEN_LF;
					end
				end else if (byte_in == CH_MINUS && !seen_q && !neg_q) begin
					neg_d = 1'b1;
				end else if (!is_digit) begin
					phase_d = PH_IDLE;
					res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_BAD_LEN};
				end else begin
					seen_d = 1'b1;
					acc_d  = acc_step;
				end
			end
			PH_LEN_LF: begin
				priority if (byte_in != CH_LF) begin
					phase_d = PH_IDLE;
					res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_NO_LF};
				end else if (neg_q) begin
					phase_d = PH_IDLE;
					res = '{1'b1, EV_DONE, kind_q, 8'd0, 32'd0, 1'b1, ERR_NONE};
				end else begin
					rem_d   = acc_q[30:0];
					phase_d = (acc_q[30:0] == 31'd0) ? PH_DATA_CR : PH_DATA;
				end
			end
			PH_DATA: begin
				rem_d = rem_dec;
				if (rem_dec == 31'd0) begin
					phase_d = PH_DATA_CR;
				end
				res = '{1'b1, EV_CONTENT, kind_q, byte_in, 32'd0, 1'b0, ERR_NONE};
			end
			PH_DATA_CR: begin
				if (byte_in != CH_CR) begin
					phase_d = PH_IDLE;
					res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_NO_LF};
				end else begin
					phase_d = PH_DATA_LF;
				end
			end
			PH_DATA_LF: begin
				phase_d = PH_IDLE;
				if (byte_in != CH_LF) begin
					res = '{1'b1, EV_ERROR, kind_q, 8'd0, 32'd0, 1'b0, ERR_NO_LF};
				end else begin
					res = '{1'b1, EV_DONE, kind_q, 8'd0, 32'd0, 1'b0, ERR_NONE};
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= KIND_SIMPLE;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
			acc_q   <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			neg_q   <= neg_d;
			seen_q  <= seen_d;
			ovf_q   <= ovf_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
		end
	end

endmodule

@@ rtl/core/kv_reply_stream_parser_core.sv @@
// kv_reply_stream_parser_core: byte-serial reply parser, one byte word per cycle while results drain.
// Path: a byte word is registered in the input stage, stepped through the parser and
// its result word registered in the result register that drives m_tvalid.
// Throughput: one byte word per cycle while m_tready drains the result register.
// Reset: arst_n low clears parser state to idle, empties both register stages
// and sets max_bulk_length to 536870912. Depends on kvrp_pkg and kvrp_parser.
module kv_reply_stream_parser_core
	import kvrp_pkg::*;
#(
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write channel: max_bulk_length
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	// input byte words
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] data_byte
	// result words
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [47:0]      m_tdata,   // [7:0] content_byte, [39:8] integer_value,
	                                    // [40] is_null, [43:41] err_code, rest zero
	output logic [4:0]       m_tuser    // [1:0] event_kind, [4:2] reply_kind
);

	logic [CFG_W-1:0] max_bulk_q;

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic       out_valid_q;
	result_t    out_q;

	result_t    res;
	logic       advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bulk_q <= MAX_BULK_RESET;
		end else if (cfg_valid) begin
			max_bulk_q <= cfg_data;
		end
	end

	// the staged byte moves into the parser when the result register is free
	// or being drained in this cycle
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	kvrp_parser #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.byte_in  (byte_s1),
		.max_bulk (max_bulk_q),
		.res      (res)
	);

	// a byte that yields no result leaves the result register empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.err_code, out_q.is_null, out_q.integer_value,
		out_q.content_byte};
	assign m_tuser  = {out_q.reply_kind, out_q.event_kind};

endmodule
